>>> src/sdld_pkg.sv
package sdld_pkg;

	// level table and widths
	localparam int LEVEL_COUNT   = 8;
	localparam int FRACTION_BITS = 16;
	localparam int LEVEL_W       = 10;
	localparam int HELD_W        = 11;
	localparam int TGT_FRAC      = 8;
	localparam int TGT_W         = 18;
	localparam int IDX_W         = $clog2(LEVEL_COUNT);
	localparam int REM_W         = TGT_W + 1;
	localparam int SUM_W         = FRACTION_BITS + 1;
	localparam int CNT_W         = $clog2(FRACTION_BITS + 1);

	localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(235008);

	localparam logic [LEVEL_W-1:0] LEVEL_TABLE [LEVEL_COUNT] = '{
		LEVEL_W'(1020), LEVEL_W'(918), LEVEL_W'(816), LEVEL_W'(714),
		LEVEL_W'(612),  LEVEL_W'(510), LEVEL_W'(408), LEVEL_W'(306)
	};

	localparam logic [TGT_W-1:0] TOP_T = {LEVEL_TABLE[0], {TGT_FRAC{1'b0}}};
	localparam logic [TGT_W-1:0] BOT_T = {LEVEL_TABLE[LEVEL_COUNT-1], {TGT_FRAC{1'b0}}};

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIVIDE,
		ST_ACCUM,
		ST_DONE
	} state_t;

	// spacing between an entry and the one above it
	function automatic logic [LEVEL_W-1:0] level_gap(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] up;
		up = idx - IDX_W'(1);
		return LEVEL_TABLE[up] - LEVEL_TABLE[idx];
	endfunction

endpackage

>>> src/sdld_sub.sv
module sdld_sub (
	input  logic [sdld_pkg::REM_W-1:0] a,
	input  logic [sdld_pkg::REM_W-1:0] b,
	output logic [sdld_pkg::REM_W-1:0] diff,
	output logic                       ge
);

	logic [sdld_pkg::REM_W:0] full;

	// shared subtractor, no borrow means a >= b
	always_comb begin
		full = {1'b0, a} - {1'b0, b};
		diff = full[sdld_pkg::REM_W-1:0];
		ge   = ~full[sdld_pkg::REM_W];
	end

endmodule

>>> src/sigma_delta_level_dither.sv
// a target at or beyond a table end goes straight to the result; otherwise the block scans
// for the bracket (1 to 7 entries), runs the 16-step divider, then the accumulate step
// the bracket scan and the 16-step divider share one subtractor; an output stall holds
// the result, and no new transaction is taken while busy
// reset: target returns to 918 MHz, accumulator and held pair clear to zero
module sigma_delta_level_dither (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sdld_pkg::TGT_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sdld_pkg::LEVEL_W-1:0]      chosen_level,
	output logic                              took_upper
);

	sdld_pkg::state_t                   state_q, state_d;
	logic [sdld_pkg::TGT_W-1:0]         target_q;
	logic [sdld_pkg::SUM_W-1:0]         sum_q;
	logic [sdld_pkg::HELD_W-1:0]        held_lower_q, held_upper_q;
	logic [sdld_pkg::IDX_W-1:0]         idx_q;
	logic [sdld_pkg::REM_W-1:0]         rem_q, den_q;
	logic [sdld_pkg::FRACTION_BITS-1:0] quo_q;
	logic [sdld_pkg::CNT_W-1:0]         cnt_q;
	logic [sdld_pkg::LEVEL_W-1:0]       res_level_q;
	logic                               res_upper_q;
	logic                               out_valid_q;
	logic [sdld_pkg::LEVEL_W-1:0]       out_level_q;
	logic                               out_upper_q;

	logic [sdld_pkg::REM_W-1:0]         op_a, op_b, sub_diff;
	logic                               sub_ge;
	logic                               accept, at_top, at_bottom, out_free;
	logic [sdld_pkg::LEVEL_W-1:0]       lower_lvl, upper_lvl;
	logic [sdld_pkg::SUM_W-1:0]         sum_next;

	assign accept    = in_valid && (state_q == sdld_pkg::ST_IDLE);
	assign at_top    = target_q >= sdld_pkg::TOP_T;
	assign at_bottom = target_q <= sdld_pkg::BOT_T;
	assign out_free  = !out_valid_q || !out_stall;
	assign lower_lvl = sdld_pkg::LEVEL_TABLE[idx_q];
	assign upper_lvl = sdld_pkg::LEVEL_TABLE[idx_q - sdld_pkg::IDX_W'(1)];
	assign sum_next  = sum_q + {1'b0, quo_q};

	// shared subtract unit
	sdld_sub u_sub (
		.a    (op_a),
		.b    (op_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdld_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (at_top || at_bottom) ? sdld_pkg::ST_DONE : sdld_pkg::ST_SEARCH;
				end
			end
			sdld_pkg::ST_SEARCH: begin
				if (sub_ge) begin
					state_d = sdld_pkg::ST_DIVIDE;
				end
			end
			sdld_pkg::ST_DIVIDE: begin
				if (cnt_q == sdld_pkg::CNT_W'(1)) begin
					state_d = sdld_pkg::ST_ACCUM;
				end
			end
			sdld_pkg::ST_ACCUM: state_d = sdld_pkg::ST_DONE;
			sdld_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sdld_pkg::ST_IDLE;
				end
			end
			default: state_d = sdld_pkg::ST_IDLE;
		endcase
	end

	// operand select for the subtractor
	always_comb begin
		case (state_q)
			sdld_pkg::ST_SEARCH: begin
				op_a = {1'b0, target_q};
				op_b = {1'b0, lower_lvl, {sdld_pkg::TGT_FRAC{1'b0}}};
			end
			default: begin
				op_a = {rem_q[sdld_pkg::REM_W-2:0], 1'b0};
				op_b = den_q;
			end
		endcase
	end

	assign in_stall     = (state_q != sdld_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign chosen_level = out_level_q;
	assign took_upper   = out_upper_q;

	// state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sdld_pkg::ST_IDLE;
			target_q <= sdld_pkg::TARGET_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				target_q <= cfg_data;
			end
		end
	end

	// accumulator and held bracket
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			held_lower_q <= '0;
			held_upper_q <= '0;
		end else begin
			if (accept && restart) begin
				sum_q        <= '0;
				held_lower_q <= '0;
				held_upper_q <= '0;
			end else if (state_q == sdld_pkg::ST_SEARCH && sub_ge) begin
				if (held_lower_q != sdld_pkg::HELD_W'(lower_lvl) ||
				    held_upper_q != sdld_pkg::HELD_W'(upper_lvl)) begin
					sum_q        <= '0;
					held_lower_q <= sdld_pkg::HELD_W'(lower_lvl);
					held_upper_q <= sdld_pkg::HELD_W'(upper_lvl);
				end
			end else if (state_q == sdld_pkg::ST_ACCUM) begin
				// overflow past one picks the upper level, dropping the carry subtracts one
				sum_q <= {1'b0, sum_next[sdld_pkg::FRACTION_BITS-1:0]};
			end
		end
	end

	// scan, divide and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sdld_pkg::ST_IDLE: begin
				idx_q <= sdld_pkg::IDX_W'(1);
				if (at_top) begin
					res_level_q <= sdld_pkg::LEVEL_TABLE[0];
				end else begin
					res_level_q <= sdld_pkg::LEVEL_TABLE[sdld_pkg::LEVEL_COUNT-1];
				end
				res_upper_q <= 1'b0;
			end
			sdld_pkg::ST_SEARCH: begin
				if (sub_ge) begin
					rem_q <= sub_diff;
					den_q <= {1'b0, sdld_pkg::level_gap(idx_q), {sdld_pkg::TGT_FRAC{1'b0}}};
					cnt_q <= sdld_pkg::CNT_W'(sdld_pkg::FRACTION_BITS);
				end else begin
					idx_q <= idx_q + sdld_pkg::IDX_W'(1);
				end
			end
			sdld_pkg::ST_DIVIDE: begin
				// restoring division, one quotient bit a cycle
				if (sub_ge) begin
					rem_q <= sub_diff;
				end else begin
					rem_q <= op_a;
				end
				quo_q <= {quo_q[sdld_pkg::FRACTION_BITS-2:0], sub_ge};
				cnt_q <= cnt_q - sdld_pkg::CNT_W'(1);
			end
			sdld_pkg::ST_ACCUM: begin
				res_upper_q <= sum_next[sdld_pkg::FRACTION_BITS];
				res_level_q <= sum_next[sdld_pkg::FRACTION_BITS] ? upper_lvl : lower_lvl;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == sdld_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sdld_pkg::ST_DONE && out_free) begin
			out_level_q <= res_level_q;
			out_upper_q <= res_upper_q;
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// one expected tick result
	typedef struct packed {
		logic [sdld_pkg::LEVEL_W-1:0] level;
		logic                         upper;
	} pick_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_write = 1'b0;
	logic [sdld_pkg::TGT_W-1:0]   cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         restart = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [sdld_pkg::LEVEL_W-1:0] chosen_level;
	logic                         took_upper;

	// dither state mirrored on the testbench side
	logic [sdld_pkg::TGT_W-1:0]   tgt_model;
	logic [sdld_pkg::SUM_W-1:0]   acc_model;
	logic [sdld_pkg::HELD_W-1:0]  held_lo_model;
	logic [sdld_pkg::HELD_W-1:0]  held_hi_model;

	bit    tick_q[$];
	pick_t pick_expect_q[$];

	bit idle_en = 1'b1;
	bit quiet = 1'b0;
	bit long_hold_done = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int err_count = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_upper = 0;
	int n_restart = 0;
	int n_cfg = 0;

	sigma_delta_level_dither dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chosen_level (chosen_level),
		.took_upper   (took_upper)
	);

	always #2 clk = ~clk;

	// next level for one tick, advancing the mirrored accumulator
	function automatic pick_t predict_level(input logic rst);
		logic [sdld_pkg::TGT_W-1:0]   t;
		logic [sdld_pkg::LEVEL_W-1:0] lo;
		logic [sdld_pkg::LEVEL_W-1:0] hi;
		longint unsigned              num;
		longint unsigned              den;
		longint unsigned              frac;
		int                           k;
		pick_t                        r;
		if (rst) begin
			acc_model = '0;
			held_lo_model = '0;
			held_hi_model = '0;
		end
		t = tgt_model;
		if (t > sdld_pkg::TOP_T) t = sdld_pkg::TOP_T;
		if (t < sdld_pkg::BOT_T) t = sdld_pkg::BOT_T;
		if (t == sdld_pkg::TOP_T) begin
			r.level = sdld_pkg::LEVEL_TABLE[0];
			r.upper = 1'b0;
			return r;
		end
		if (t == sdld_pkg::BOT_T) begin
			r.level = sdld_pkg::LEVEL_TABLE[sdld_pkg::LEVEL_COUNT-1];
			r.upper = 1'b0;
			return r;
		end
		// first entry at or below the target
		k = 1;
		while (k < sdld_pkg::LEVEL_COUNT - 1 &&
		       (32'(sdld_pkg::LEVEL_TABLE[sdld_pkg::IDX_W'(k)]) << sdld_pkg::TGT_FRAC) > 32'(t))
			k++;
		lo = sdld_pkg::LEVEL_TABLE[sdld_pkg::IDX_W'(k)];
		hi = sdld_pkg::LEVEL_TABLE[sdld_pkg::IDX_W'(k - 1)];
		if (sdld_pkg::HELD_W'(lo) != held_lo_model || sdld_pkg::HELD_W'(hi) != held_hi_model) begin
			acc_model = '0;
			held_lo_model = sdld_pkg::HELD_W'(lo);
			held_hi_model = sdld_pkg::HELD_W'(hi);
		end
		num = 64'(t) - (64'(lo) << sdld_pkg::TGT_FRAC);
		den = 64'(hi - lo) << sdld_pkg::TGT_FRAC;
		frac = (num << sdld_pkg::FRACTION_BITS) / den;
		if (frac >= (64'(1) << sdld_pkg::FRACTION_BITS))
			frac = (64'(1) << sdld_pkg::FRACTION_BITS) - 64'(1);
		acc_model = sdld_pkg::SUM_W'(64'(acc_model) + frac);
		if (acc_model[sdld_pkg::FRACTION_BITS]) begin
			acc_model[sdld_pkg::FRACTION_BITS] = 1'b0;
			r.level = hi;
			r.upper = 1'b1;
		end else begin
			r.level = lo;
			r.upper = 1'b0;
		end
		return r;
	endfunction

	// driver: offer queued ticks, predict on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pick_expect_q.insert(pick_expect_q.size(), predict_level(restart));
				n_sent++;
				if (restart) n_restart++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					in_valid <= 1'b1;
					restart <= tick_q.pop_front();
					if (idle_en && !quiet && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction, drive output stall
	always @(posedge clk) begin
		pick_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pick_expect_q.size() == 0) begin
					$display("%0t: unexpected result, got level %0d upper %0b",
						$time, chosen_level, took_upper);
					err_count++;
				end else begin
					e = pick_expect_q.pop_front();
					if (chosen_level !== e.level) begin
						$display("%0t: chosen_level expected %0d got %0d",
							$time, e.level, chosen_level);
						err_count++;
					end
					if (took_upper !== e.upper) begin
						$display("%0t: took_upper expected %0b got %0b",
							$time, e.upper, took_upper);
						err_count++;
					end
					if (e.upper) n_upper++;
				end
				n_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && n_checked >= 300 && tick_q.size() >= 8) begin
				// long hold so the block backs up and stalls its input
				long_hold_done = 1'b1;
				hold_left = 199;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_en && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// wait until nothing is queued, offered or outstanding
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_q.size() > 0 || in_valid || pick_expect_q.size() > 0);
	endtask

	// write the target while the block is idle
	task automatic set_target(input logic [sdld_pkg::TGT_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		tgt_model = v;
		n_cfg++;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// queue one tick at the tail
	task automatic add_tick(input bit r);
		tick_q.insert(tick_q.size(), r);
	endtask

	task automatic push_ticks(input int n, input int restart_odds);
		for (int i = 0; i < n; i++)
			add_tick(restart_odds > 0 && $urandom_range(0, restart_odds - 1) == 0);
	endtask

	function automatic logic [sdld_pkg::TGT_W-1:0] pick_target();
		int lvl;
		logic [sdld_pkg::TGT_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = sdld_pkg::TOP_T;
			1: v = sdld_pkg::BOT_T;
			2: v = sdld_pkg::TGT_W'(sdld_pkg::LEVEL_TABLE[
				sdld_pkg::IDX_W'($urandom_range(1, sdld_pkg::LEVEL_COUNT - 2))])
				<< sdld_pkg::TGT_FRAC;
			3: begin
				// one step off a table level
				lvl = $urandom_range(0, sdld_pkg::LEVEL_COUNT - 1);
				v = sdld_pkg::TGT_W'(sdld_pkg::LEVEL_TABLE[sdld_pkg::IDX_W'(lvl)])
					<< sdld_pkg::TGT_FRAC;
				if (lvl == 0) v = v - sdld_pkg::TGT_W'(1);
				else if (lvl == sdld_pkg::LEVEL_COUNT - 1) v = v + sdld_pkg::TGT_W'(1);
				else if ($urandom_range(0, 1)) v = v + sdld_pkg::TGT_W'(1);
				else v = v - sdld_pkg::TGT_W'(1);
			end
			default: v = sdld_pkg::TGT_W'($urandom_range(sdld_pkg::BOT_T, sdld_pkg::TOP_T));
		endcase
		return v;
	endfunction

	initial begin
		int n;
		tgt_model = sdld_pkg::TARGET_RESET;
		acc_model = '0;
		held_lo_model = '0;
		held_hi_model = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset target sits on an inner level
		add_tick(1'b0);
		add_tick(1'b0);
		add_tick(1'b1);
		add_tick(1'b0);
		// top and bottom of the table, held pair must survive
		set_target(sdld_pkg::TOP_T);
		add_tick(1'b0);
		add_tick(1'b1);
		set_target(sdld_pkg::BOT_T);
		add_tick(1'b0);
		add_tick(1'b1);
		// just inside each end
		set_target(sdld_pkg::BOT_T + sdld_pkg::TGT_W'(1));
		add_tick(1'b0);
		add_tick(1'b0);
		set_target(sdld_pkg::TOP_T - sdld_pkg::TGT_W'(1));
		add_tick(1'b0);
		add_tick(1'b0);
		add_tick(1'b0);
		// exact inner level, then a midpoint with restart in the middle
		set_target(sdld_pkg::TGT_W'(714) << sdld_pkg::TGT_FRAC);
		add_tick(1'b0);
		add_tick(1'b0);
		set_target(sdld_pkg::TGT_W'(765) << sdld_pkg::TGT_FRAC);
		add_tick(1'b0);
		add_tick(1'b0);
		add_tick(1'b1);
		add_tick(1'b0);
		add_tick(1'b0);

		// random phases, each at one target
		while (n_sent + tick_q.size() < 950) begin
			set_target(pick_target());
			n = $urandom_range(10, 60);
			if (950 - n_sent <= 100) begin
				quiet = 1'b1;
				n = 100;
			end
			idle_en = ($urandom_range(0, 3) != 0);
			push_ticks(n, 16);
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("tb_top: %0d ticks checked, %0d took the upper level, %0d with restart",
			n_checked, n_upper, n_restart);
		$display("tb_top: %0d target writes, stalls on both sides and one long output hold",
			n_cfg);
		if (err_count == 0 && pick_expect_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
